[src/multilevel_feedback_scheduler_core_defines.svh]
// Assertion macros for the multilevel feedback scheduler.
// Used by the top level only; needs clock and reset in scope.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_CORE_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MLFS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define MLFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/mlfs_pkg.sv]
// Shared field widths and constants of the multilevel feedback scheduler.
// No dependencies; used by the channel interfaces and the core.
package mlfs_pkg;

   localparam int ID_BITS           = 4;
   localparam int LEVEL_BITS        = 3;
   localparam int CFG_BITS          = 4;
   localparam int SLICE_BITS        = 8;
   localparam int LEVEL_COUNT_RESET = 3;

endpackage

[src/mlfs_chan_if.sv]
// Valid/ready channel interfaces: tick request in, dispatch response out.
// Depends on mlfs_pkg for the field widths.
interface mlfs_req_if import mlfs_pkg::*; #(parameter int DURATION_BITS = 16) ();
   logic                     valid;
   logic                     ready;
   logic                     arrive_valid;
   logic [ID_BITS-1:0]       arrive_id;
   logic [DURATION_BITS-1:0] arrive_duration;

   modport source (output valid, output arrive_valid, output arrive_id,
                   output arrive_duration, input ready);
   modport sink   (input valid, input arrive_valid, input arrive_id,
                   input arrive_duration, output ready);
endinterface

interface mlfs_rsp_if import mlfs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  running_valid;
   logic [ID_BITS-1:0]    running_id;
   logic [LEVEL_BITS-1:0] running_level;
   logic                  task_finished;
   logic                  arrival_dropped;

   modport source (output valid, output running_valid, output running_id,
                   output running_level, output task_finished,
                   output arrival_dropped, input ready);
   modport sink   (input valid, input running_valid, input running_id,
                   input running_level, input task_finished,
                   input arrival_dropped, output ready);
endinterface

[src/mlfs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mlfs_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/multilevel_feedback_scheduler_core.sv]
// Multilevel feedback queue scheduler core: per-level FIFOs in one RAM.
// Depends on mlfs_pkg, mlfs_chan_if, mlfs_ram and the defines header.
//
//  channel  | dir | transfer moves
//  ---------+-----+-------------------------------------------------
//  req_ch   | in  | one tick: arrive_valid, arrive_id, arrive_duration
//  rsp_ch   | out | one result per tick: running task, finished, dropped
//  csr_*    | in  | level_count write, no read-back
//
// A tick steps through accept, level 0 enqueue, demotion check or empty scan,
// and result; loading a task adds a store read, and a demotion adds a scan.
// The queue store, used for one access per cycle, sets this order of steps.
// Reset (synchronous) empties all levels and leaves no task running.
// The result waits in an output register; the next tick is accepted while it
// waits, and a tick is held in its last step until the register frees.
`include "multilevel_feedback_scheduler_core_defines.svh"

module multilevel_feedback_scheduler_core import mlfs_pkg::*; #(
   parameter int MAX_LEVELS    = 8,
   parameter int QUEUE_DEPTH   = 16,
   parameter int DURATION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   mlfs_req_if.sink            req_ch,
   mlfs_rsp_if.source          rsp_ch,
   input  logic                csr_wr_en,
   input  logic [CFG_BITS-1:0] csr_wr_data
);

   localparam int LVL_W       = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH = MAX_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int ENTRY_W     = ID_BITS + DURATION_BITS;

   // sequencer codes
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PUSH0  = 3'd1;
   localparam logic [2:0] S_DEMOTE = 3'd2;
   localparam logic [2:0] S_DISP   = 3'd3;
   localparam logic [2:0] S_LOAD   = 3'd4;
   localparam logic [2:0] S_RUN    = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [CFG_BITS-1:0]       level_count_ff;
   logic [CFG_BITS-1:0]       nlev_ff;
   logic                      arr_valid_ff;
   logic [ID_BITS-1:0]        arr_id_ff;
   logic [DURATION_BITS-1:0]  arr_dur_ff;
   logic                      dropped_ff;

   logic [PTR_W-1:0]          head_ff [MAX_LEVELS];
   logic [PTR_W-1:0]          tail_ff [MAX_LEVELS];
   logic [FILL_W-1:0]         fill_ff [MAX_LEVELS];

   logic [ID_BITS-1:0]        cur_id_ff;
   logic [DURATION_BITS-1:0]  cur_rem_ff;
   logic [LEVEL_BITS-1:0]     cur_level_ff;
   logic [SLICE_BITS-1:0]     slice_ff;
   logic [LVL_W-1:0]          disp_lvl_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_run_ff;
   logic [ID_BITS-1:0]        rsp_id_ff;
   logic [LEVEL_BITS-1:0]     rsp_level_ff;
   logic                      rsp_fin_ff;
   logic                      rsp_drop_ff;

   logic                      req_xfer;
   logic                      out_free;
   logic [CFG_BITS-1:0]       nlev_sat;
   logic                      demote_cond;
   logic                      found;
   logic [LVL_W-1:0]          found_lvl;
   logic [LVL_W-1:0]          op_lvl;
   logic                      op_push;
   logic                      op_pop;
   logic                      op_full;
   logic [PTR_W-1:0]          op_ptr;
   logic [ADDR_W-1:0]         store_addr;
   logic [ENTRY_W-1:0]        store_wr_data;
   logic [ENTRY_W-1:0]        store_rd_data;
   logic [DURATION_BITS-1:0]  rem_dec;

   // channel handshakes
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // level count clamped to 1..MAX_LEVELS
   always_comb begin
      nlev_sat = level_count_ff;
      if (level_count_ff == '0) begin
         nlev_sat = CFG_BITS'(1);
      end else if (level_count_ff > CFG_BITS'(MAX_LEVELS)) begin
         nlev_sat = CFG_BITS'(MAX_LEVELS);
      end
   end

   // slice used up below the last level in use
   assign demote_cond = (CFG_BITS'(cur_level_ff) + CFG_BITS'(1) < nlev_ff) &&
                        (slice_ff >= (SLICE_BITS'(1) << cur_level_ff));

   // first non-empty level in use
   always_comb begin
      found     = 1'b0;
      found_lvl = '0;
      for (int l = 0; l < MAX_LEVELS; l++) begin
         if (!found && (CFG_BITS'(l) < nlev_ff) && (fill_ff[l] != '0)) begin
            found     = 1'b1;
            found_lvl = LVL_W'(l);
         end
      end
   end

   // shared queue unit: one level, one push or pop per cycle
   always_comb begin
      op_lvl  = '0;
      op_push = 1'b0;
      op_pop  = 1'b0;
      unique case (state_ff)
         S_PUSH0: begin
            op_lvl  = '0;
            op_push = arr_valid_ff && !op_full;
         end
         S_DEMOTE: begin
            op_lvl  = LVL_W'(cur_level_ff + LEVEL_BITS'(1));
            op_push = demote_cond && !op_full;
         end
         S_DISP: begin
            op_lvl = found_lvl;
            op_pop = found;
         end
         default: begin
            op_lvl = '0;
         end
      endcase
   end

   assign op_full    = (fill_ff[op_lvl] == FILL_W'(QUEUE_DEPTH));
   assign op_ptr     = op_push ? tail_ff[op_lvl] : head_ff[op_lvl];
   assign store_addr = ADDR_W'(int'(op_lvl) * QUEUE_DEPTH + int'(op_ptr));
   assign store_wr_data = (state_ff == S_PUSH0) ? {arr_id_ff, arr_dur_ff}
                                                : {cur_id_ff, cur_rem_ff};
   assign rem_dec    = cur_rem_ff - DURATION_BITS'(1);

   mlfs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (op_push),
      .wr_addr (store_addr),
      .wr_data (store_wr_data),
      .rd_en   (op_pop),
      .rd_addr (store_addr),
      .rd_data (store_rd_data)
   );

   // queue pointers and fill counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < MAX_LEVELS; l++) begin
            head_ff[l] <= '0;
            tail_ff[l] <= '0;
            fill_ff[l] <= '0;
         end
      end else if (op_push) begin
         tail_ff[op_lvl] <= (tail_ff[op_lvl] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : tail_ff[op_lvl] + PTR_W'(1);
         fill_ff[op_lvl] <= fill_ff[op_lvl] + FILL_W'(1);
      end else if (op_pop) begin
         head_ff[op_lvl] <= (head_ff[op_lvl] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : head_ff[op_lvl] + PTR_W'(1);
         fill_ff[op_lvl] <= fill_ff[op_lvl] - FILL_W'(1);
      end
   end

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= CFG_BITS'(LEVEL_COUNT_RESET);
      end else if (csr_wr_en) begin
         level_count_ff <= csr_wr_data;
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_xfer) state_in = S_PUSH0;
         S_PUSH0:  state_in = (cur_rem_ff == '0) ? S_DISP : S_DEMOTE;
         S_DEMOTE: state_in = op_push ? S_DISP : S_RUN;
         S_DISP:   state_in = found ? S_LOAD : S_RUN;
         S_LOAD:   state_in = S_RUN;
         S_RUN:    if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // latched tick and running task
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_id_ff    <= '0;
         cur_rem_ff   <= '0;
         cur_level_ff <= '0;
         slice_ff     <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  arr_valid_ff <= req_ch.arrive_valid;
                  arr_id_ff    <= req_ch.arrive_id;
                  arr_dur_ff   <= (req_ch.arrive_duration == '0) ? DURATION_BITS'(1)
                                  : req_ch.arrive_duration;
                  nlev_ff      <= nlev_sat;
               end
            end
            S_PUSH0: begin
               dropped_ff <= arr_valid_ff && op_full;
            end
            S_DISP: begin
               disp_lvl_ff <= found_lvl;
               if (!found) begin
                  cur_rem_ff <= '0;
                  slice_ff   <= '0;
               end
            end
            S_LOAD: begin
               cur_id_ff    <= store_rd_data[ENTRY_W-1 -: ID_BITS];
               cur_rem_ff   <= store_rd_data[DURATION_BITS-1:0];
               cur_level_ff <= LEVEL_BITS'(disp_lvl_ff);
               slice_ff     <= '0;
            end
            S_RUN: begin
               if (out_free && (cur_rem_ff != '0)) begin
                  cur_rem_ff <= rem_dec;
                  if (slice_ff != '1) begin
                     slice_ff <= slice_ff + SLICE_BITS'(1);
                  end
               end
            end
            default: begin
               dropped_ff <= dropped_ff;
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_RUN) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_RUN) && out_free) begin
         rsp_run_ff   <= (cur_rem_ff != '0);
         rsp_id_ff    <= (cur_rem_ff != '0) ? cur_id_ff : '0;
         rsp_level_ff <= (cur_rem_ff != '0) ? cur_level_ff : '0;
         rsp_fin_ff   <= (cur_rem_ff != '0) && (rem_dec == '0);
         rsp_drop_ff  <= dropped_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.running_valid   = rsp_run_ff;
   assign rsp_ch.running_id      = rsp_id_ff;
   assign rsp_ch.running_level   = rsp_level_ff;
   assign rsp_ch.task_finished   = rsp_fin_ff;
   assign rsp_ch.arrival_dropped = rsp_drop_ff;

   // checks
   `MLFS_ASSERT_NEXT(a_accept_starts_tick, req_xfer, state_ff == S_PUSH0,
                     "accepted tick did not start the enqueue step")
   `MLFS_ASSERT_NEXT(a_load_nonzero, state_ff == S_LOAD, cur_rem_ff != '0,
                     "dispatched task has no remaining time")
   `MLFS_ASSERT_NOW(a_level0_bound, 1'b1, fill_ff[0] <= FILL_W'(QUEUE_DEPTH),
                    "level 0 fill count beyond queue depth")

endmodule

[dv/testbench.sv]
// Self-checking testbench for multilevel_feedback_scheduler_core: a tick driver,
// a result checker with its own scheduler predictor, and random idling on both sides.
// Depends on mlfs_pkg, the mlfs_req_if / mlfs_rsp_if channels and the core RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mlfs_pkg::*;

   localparam int MAX_LEVELS    = 8;
   localparam int QUEUE_DEPTH   = 16;
   localparam int DURATION_BITS = 16;
   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SLICE_MAX     = (1 << SLICE_BITS) - 1;
   localparam int PHASE_TICKS   = 50;
   localparam int unsigned PHASE_LEVELS [9] = '{8, 2, 15, 1, 5, 4, 6, 7, 15};

   typedef enum logic [1:0] {STEP_TICK, STEP_CONFIG, STEP_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type            kind;
      logic                     arrive;
      logic [ID_BITS-1:0]       id;
      logic [DURATION_BITS-1:0] duration;
      logic [CFG_BITS-1:0]      levels;
   } stim_step_type;

   typedef struct packed {
      logic [ID_BITS-1:0]       id;
      logic [DURATION_BITS-1:0] remaining;
   } waiting_task_type;

   typedef struct packed {
      logic                  running_valid;
      logic [ID_BITS-1:0]    running_id;
      logic [LEVEL_BITS-1:0] running_level;
      logic                  task_finished;
      logic                  arrival_dropped;
   } tick_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Driven values, known from time zero
   logic                     tick_valid    = 1'b0;
   logic                     tick_arrive   = 1'b0;
   logic [ID_BITS-1:0]       tick_id       = '0;
   logic [DURATION_BITS-1:0] tick_duration = '0;
   logic                     result_ready  = 1'b0;
   logic                     csr_wr_en     = 1'b0;
   logic [CFG_BITS-1:0]      csr_wr_data   = '0;

   mlfs_req_if #(.DURATION_BITS(DURATION_BITS)) req_if ();
   mlfs_rsp_if rsp_if ();

   assign req_if.valid           = tick_valid;
   assign req_if.arrive_valid    = tick_arrive;
   assign req_if.arrive_id       = tick_id;
   assign req_if.arrive_duration = tick_duration;
   assign rsp_if.ready           = result_ready;

   multilevel_feedback_scheduler_core #(
      .MAX_LEVELS   (MAX_LEVELS),
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .DURATION_BITS(DURATION_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   stim_step_type   stimulus[$];
   tick_result_type dispatch_forecast[$];
   int unsigned     mismatches = 0;
   int unsigned     cycle_count = 0;

   // Predictor state: per-level FIFOs, the running task, the level count
   waiting_task_type    level_store [MAX_LEVELS][QUEUE_DEPTH];
   int unsigned         lvl_head [MAX_LEVELS];
   int unsigned         lvl_tail [MAX_LEVELS];
   int unsigned         lvl_fill [MAX_LEVELS];
   logic [ID_BITS-1:0]  run_id;
   logic [DURATION_BITS-1:0] run_left;
   int unsigned         run_level;
   int unsigned         run_slice;
   logic [CFG_BITS-1:0] levels_in_use;

   // Handshake bookkeeping
   int unsigned send_wait = 0;
   int unsigned send_mode = 1;
   int unsigned stall_left = 0;
   int unsigned stall_mode = 1;
   int unsigned ticks_sent = 0;
   int unsigned results_seen = 0;
   int unsigned settle_count = 0;

   function automatic bit enqueue_task(int unsigned lvl, logic [ID_BITS-1:0] id,
                                       logic [DURATION_BITS-1:0] remaining);
      if (lvl >= MAX_LEVELS || lvl_fill[lvl] >= QUEUE_DEPTH) return 1'b0;
      level_store[lvl][lvl_tail[lvl]] = '{id: id, remaining: remaining};
      lvl_tail[lvl] = (lvl_tail[lvl] + 1) % QUEUE_DEPTH;
      lvl_fill[lvl]++;
      return 1'b1;
   endfunction

   // Load the head of the first non-empty level in use, or go idle
   function automatic void dispatch_next(int unsigned nlev);
      run_left  = '0;
      run_slice = 0;
      for (int unsigned lvl = 0; lvl < nlev; lvl++) begin
         if (lvl_fill[lvl] != 0) begin
            run_id    = level_store[lvl][lvl_head[lvl]].id;
            run_left  = level_store[lvl][lvl_head[lvl]].remaining;
            run_level = lvl;
            lvl_head[lvl] = (lvl_head[lvl] + 1) % QUEUE_DEPTH;
            lvl_fill[lvl]--;
            return;
         end
      end
   endfunction

   // One scheduler tick: enqueue arrival, dispatch or demote, run one tick
   function automatic tick_result_type schedule_tick(logic arrive,
                                                     logic [ID_BITS-1:0] id,
                                                     logic [DURATION_BITS-1:0] duration);
      tick_result_type          res;
      int unsigned              nlev;
      logic [DURATION_BITS-1:0] need;
      res  = '0;
      nlev = (levels_in_use == 0) ? 1 :
             (levels_in_use > MAX_LEVELS) ? MAX_LEVELS : levels_in_use;
      if (arrive) begin
         need = (duration == 0) ? DURATION_BITS'(1) : duration;
         if (!enqueue_task(0, id, need)) res.arrival_dropped = 1'b1;
      end
      if (run_left == 0) begin
         dispatch_next(nlev);
      end else if (run_level + 1 < nlev && run_slice >= (1 << run_level)) begin
         // a full next level leaves the task running
         if (enqueue_task(run_level + 1, run_id, run_left)) dispatch_next(nlev);
      end
      if (run_left != 0) begin
         res.running_valid = 1'b1;
         res.running_id    = run_id;
         res.running_level = LEVEL_BITS'(run_level);
         run_left--;
         res.task_finished = (run_left == 0);
         if (run_slice < SLICE_MAX) run_slice++;
      end
      return res;
   endfunction

   // Wait before the next transfer: none, uniform random, or mostly none
   function automatic int unsigned draw_wait(int unsigned mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 19);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
      endcase
   endfunction

   function automatic void add_tick(logic arrive, logic [ID_BITS-1:0] id,
                                    logic [DURATION_BITS-1:0] duration);
      stimulus.push_back('{kind: STEP_TICK, arrive: arrive, id: id,
                           duration: duration, levels: '0});
   endfunction

   function automatic void add_control(step_kind_type kind, logic [CFG_BITS-1:0] levels);
      stimulus.push_back('{kind: kind, arrive: 1'b0, id: '0, duration: '0, levels: levels});
   endfunction

   // Mostly short tasks; long ones only where they cannot stall the rest of the run
   function automatic void add_random_tick(int unsigned arrive_pct, bit long_ok);
      logic [DURATION_BITS-1:0] dur;
      int unsigned              pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)        dur = '0;
      else if (pick < 60)  dur = DURATION_BITS'($urandom_range(1, 8));
      else if (pick < 85)  dur = DURATION_BITS'($urandom_range(9, 40));
      else if (pick < 97)  dur = DURATION_BITS'($urandom_range(41, 300));
      else if (long_ok)    dur = DURATION_BITS'($urandom_range(0, 65535));
      else                 dur = DURATION_BITS'($urandom_range(301, 600));
      add_tick($urandom_range(0, 99) < arrive_pct, ID_BITS'($urandom_range(0, 15)), dur);
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Tick driver: presents queued ticks, performs level count writes when idle
   always @(posedge clock) begin : drive_ticks
      stim_step_type       step;
      logic                nxt_valid;
      logic                nxt_wen;
      logic [CFG_BITS-1:0] nxt_wdata;
      nxt_valid = tick_valid;
      nxt_wen   = 1'b0;
      nxt_wdata = csr_wr_data;
      if (reset) begin
         nxt_valid    = 1'b0;
         send_wait    = 0;
         ticks_sent   = 0;
         results_seen = 0;
         settle_count = 0;
      end else begin
         if (tick_valid && req_if.ready) begin
            nxt_valid = 1'b0;
            ticks_sent++;
         end
         if (rsp_if.valid && result_ready) results_seen++;
         if (!nxt_valid && !csr_wr_en) begin
            if (send_wait != 0) begin
               send_wait--;
            end else if (stimulus.size() != 0) begin
               step = stimulus[0];
               if (step.kind == STEP_TICK) begin
                  nxt_valid = 1'b1;
                  tick_arrive   <= step.arrive;
                  tick_id       <= step.id;
                  tick_duration <= step.duration;
                  void'(stimulus.pop_front());
                  send_wait = draw_wait(send_mode);
                  if ($urandom_range(0, 29) == 0) send_mode = $urandom_range(0, 2);
               end else if (ticks_sent != results_seen) begin
                  settle_count = 0;
               end else if (settle_count < SETTLE_CYCLES) begin
                  settle_count++;
               end else begin
                  if (step.kind == STEP_CONFIG) begin
                     nxt_wen   = 1'b1;
                     nxt_wdata = step.levels;
                  end
                  void'(stimulus.pop_front());
                  settle_count = 0;
               end
            end
         end
      end
      tick_valid  <= nxt_valid;
      csr_wr_en   <= nxt_wen;
      csr_wr_data <= nxt_wdata;
   end

   // Result checker and predictor; drives the result-side ready
   always @(posedge clock) begin : score_ticks
      tick_result_type got;
      tick_result_type want;
      if (reset) begin
         for (int l = 0; l < MAX_LEVELS; l++) begin
            lvl_head[l] = 0;
            lvl_tail[l] = 0;
            lvl_fill[l] = 0;
         end
         run_id        = '0;
         run_left      = '0;
         run_level     = 0;
         run_slice     = 0;
         levels_in_use = CFG_BITS'(LEVEL_COUNT_RESET);
         stall_left    = 0;
         result_ready <= 1'b0;
      end else begin
         // a result can never belong to a tick accepted on this same edge
         if (rsp_if.valid && result_ready) begin
            got = {rsp_if.running_valid, rsp_if.running_id, rsp_if.running_level,
                   rsp_if.task_finished, rsp_if.arrival_dropped};
            if (dispatch_forecast.size() == 0) begin
               $display("%0t: result expected none got %p", $time, got);
               mismatches++;
            end else begin
               want = dispatch_forecast.pop_front();
               check_field("running_valid", want.running_valid, got.running_valid);
               check_field("running_id", want.running_id, got.running_id);
               check_field("running_level", want.running_level, got.running_level);
               check_field("task_finished", want.task_finished, got.task_finished);
               check_field("arrival_dropped", want.arrival_dropped, got.arrival_dropped);
            end
            stall_left = draw_wait(stall_mode);
            if ($urandom_range(0, 29) == 0) stall_mode = $urandom_range(0, 2);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         if (csr_wr_en) levels_in_use = csr_wr_data;
         if (tick_valid && req_if.ready)
            dispatch_forecast.push_back(schedule_tick(tick_arrive, tick_id, tick_duration));
         result_ready <= (stall_left == 0);
      end
   end

   // Run limit
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin : run_test
      int unsigned arrive_pct;
      arrive_pct = 50;

      // Default level count: zero duration, idle tick, demotion down to the FCFS level
      add_tick(1'b1, 4'd0, 16'd0);
      add_tick(1'b0, 4'd12, 16'hA5A5);
      add_tick(1'b1, 4'd15, 16'd7);
      add_tick(1'b1, 4'd5, 16'd2);
      add_tick(1'b0, 4'd0, 16'd0);
      add_tick(1'b0, 4'd0, 16'd0);
      add_tick(1'b0, 4'd0, 16'd0);

      // Level count zero acts as one: a long task blocks, level 0 fills, then drops
      add_control(STEP_CONFIG, 4'd0);
      add_tick(1'b1, 4'd9, 16'd40);
      for (int i = 0; i < 17; i++)
         add_tick(1'b1, ID_BITS'(i), DURATION_BITS'(1 + i % 3));

      // Random phases over level counts, including saturation; last one has long tasks
      foreach (PHASE_LEVELS[p]) begin
         add_control(STEP_CONFIG, CFG_BITS'(PHASE_LEVELS[p]));
         if (p == $size(PHASE_LEVELS) - 1) add_tick(1'b1, 4'd3, '1);
         for (int n = 0; n < PHASE_TICKS; n++) begin
            if (n % 10 == 0) begin
               case ($urandom_range(0, 2))
                  0: arrive_pct = 10;
                  1: arrive_pct = 50;
                  default: arrive_pct = 95;
               endcase
            end
            if (n == PHASE_TICKS / 2 && p % 3 == 1) add_control(STEP_DRAIN, '0);
            add_random_tick(arrive_pct, p == $size(PHASE_LEVELS) - 1);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (stimulus.size() != 0 || tick_valid || dispatch_forecast.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
